// ===== design/pida_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pida_pkg;

    // number of array entries, bounded by the 7-bit position and count fields
    localparam int DEPTH = 64;

    // field widths of one request and one result word
    localparam int OP_W     = 2;
    localparam int POS_W    = 7;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 7;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    // request codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture request, run checks, set index
        logic wr_shift;  // write moved entry at index, step index
        logic wr_value;  // write inserted word at position
        logic finish;    // load result register, update count
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            chk_ok;
        logic            more;
        logic            out_free;
    } sts_t;

endpackage

`default_nettype wire

// ===== design/pida_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pida_ctrl
    import pida_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    typedef enum logic [2:0] {
        IDLE,
        DECIDE,
        SHIFT_WR,
        INS_WR,
        FINISH
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = DECIDE;
                end
            end
            DECIDE: begin
                // read of the source entry is issued in this cycle
                if (!sts.chk_ok) begin
                    state_next = FINISH;
                end else if (sts.op == OP_INSERT) begin
                    state_next = sts.more ? SHIFT_WR : INS_WR;
                end else if (sts.op == OP_DELETE) begin
                    state_next = sts.more ? SHIFT_WR : FINISH;
                end else begin
                    state_next = FINISH;
                end
            end
            SHIFT_WR: begin
                cmd.wr_shift = 1'b1;
                state_next   = DECIDE;
            end
            INS_WR: begin
                cmd.wr_value = 1'b1;
                state_next   = FINISH;
            end
            FINISH: begin
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/pida_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pida_dp
    import pida_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [OP_W-1:0]      in_op,
    input  wire logic [POS_W-1:0]     in_pos,
    input  wire logic [VALUE_W-1:0]   in_value,
    input  wire cmd_t                 cmd,
    output sts_t                      sts,
    input  wire logic                 m_tready,
    output logic                      m_tvalid,
    output logic [STATUS_W-1:0]       out_status,
    output logic [VALUE_W-1:0]        out_read_value,
    output logic [FILL_W-1:0]         out_fill_count
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] rd_data_reg;

    logic [OP_W-1:0]     op_reg;
    logic [XW-1:0]       pos_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic [STATUS_W-1:0] chk_reg;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [CW-1:0]       count_reg, count_next;

    logic                m_tvalid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [VALUE_W-1:0]  read_value_reg;
    logic [FILL_W-1:0]   fill_reg;

    logic [XW-1:0]       in_pos_x, count_x, idx_x;
    logic [STATUS_W-1:0] chk_next;
    logic [CW-1:0]       idx_dn, idx_up;
    logic [AW-1:0]       rd_addr, wr_addr;
    logic [VALUE_W-1:0]  wr_data;
    logic                mem_we;

    assign in_pos_x = XW'(in_pos);
    assign count_x  = XW'(count_reg);
    assign idx_x    = XW'(idx_reg);
    assign idx_dn   = idx_reg - CW'(1);
    assign idx_up   = idx_reg + CW'(1);

    // request checks against the current count
    always_comb begin
        case (in_op)
            OP_INSERT: begin
                if (count_reg == CW'(DEPTH)) chk_next = ST_FULL;
                else if (in_pos_x > count_x)  chk_next = ST_BADPOS;
                else                          chk_next = ST_OK;
            end
            OP_DELETE, OP_READ: begin
                if (count_reg == '0)          chk_next = ST_EMPTY;
                else if (in_pos_x >= count_x) chk_next = ST_BADPOS;
                else                          chk_next = ST_OK;
            end
            default: chk_next = ST_BADPOS;
        endcase
    end

    // read address: source of the next move, or the position for a read
    always_comb begin
        case (op_reg)
            OP_INSERT: rd_addr = idx_dn[AW-1:0];
            OP_DELETE: rd_addr = idx_up[AW-1:0];
            default:   rd_addr = pos_reg[AW-1:0];
        endcase
    end

    assign mem_we  = cmd.wr_shift | cmd.wr_value;
    assign wr_addr = cmd.wr_value ? pos_reg[AW-1:0] : idx_reg[AW-1:0];
    assign wr_data = cmd.wr_value ? value_reg : rd_data_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb begin
        idx_next = idx_reg;
        if (cmd.load) begin
            idx_next = (in_op == OP_INSERT) ? count_reg : CW'(in_pos_x);
        end else if (cmd.wr_shift) begin
            idx_next = (op_reg == OP_INSERT) ? idx_dn : idx_up;
        end
    end

    always_comb begin
        count_next = count_reg;
        if (chk_reg == ST_OK) begin
            if (op_reg == OP_INSERT)      count_next = count_reg + CW'(1);
            else if (op_reg == OP_DELETE) count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= in_op;
            pos_reg   <= in_pos_x;
            value_reg <= in_value;
            chk_reg   <= chk_next;
        end
        idx_reg <= idx_next;
        if (cmd.finish) begin
            status_reg     <= chk_reg;
            read_value_reg <= (op_reg == OP_READ && chk_reg == ST_OK) ? rd_data_reg : '0;
            fill_reg       <= FILL_W'(count_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.finish) begin
                count_reg <= count_next;
            end
            if (cmd.finish) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign sts.op       = op_reg;
    assign sts.chk_ok   = (chk_reg == ST_OK);
    assign sts.more     = (op_reg == OP_INSERT) ? (idx_x > pos_reg)
                        : ({1'b0, idx_reg} + (CW + 1)'(1) < {1'b0, count_reg});
    assign sts.out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid       = m_tvalid_reg;
    assign out_status     = status_reg;
    assign out_read_value = read_value_reg;
    assign out_fill_count = fill_reg;

endmodule

`default_nettype wire

// ===== design/positional_insert_delete_array.sv =====
`timescale 1ns / 1ps
`default_nettype none

// ordered array of DEPTH signed 32-bit words with a fill count, held in a
// single-port-write, registered-read memory. each input word is an insert,
// a delete or a read at a zero-based position; each gives exactly one result
// word with status (ok, full, empty, invalid position), the read entry for a
// successful read (else zero) and the count after the request. a failed
// request changes nothing. inserts and deletes move the later entries one at
// a time through the memory port, each move a read in DECIDE and a write in
// SHIFT_WR. the result sits in an output register, so the next request is
// taken while the previous result waits for m_tready. the array contents
// after reset are undefined; only entries below the count are ever used.

module positional_insert_delete_array
    import pida_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // request: [1:0] operation, [8:2] position, [40:9] value, zero above
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // result: [1:0] status, [33:2] read_value, [40:34] fill_count, zero above
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata
);

    cmd_t cmd;
    sts_t sts;

    logic [STATUS_W-1:0] out_status;
    logic [VALUE_W-1:0]  out_read_value;
    logic [FILL_W-1:0]   out_fill_count;

    // sequencer: request intake, shift loop, result handoff
    pida_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // array memory, count, request checks and result register
    pida_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_op          (s_tdata[1:0]),
        .in_pos         (s_tdata[8:2]),
        .in_value       (s_tdata[40:9]),
        .cmd            (cmd),
        .sts            (sts),
        .m_tready       (m_tready),
        .m_tvalid       (m_tvalid),
        .out_status     (out_status),
        .out_read_value (out_read_value),
        .out_fill_count (out_fill_count)
    );

    // pack the result word, padding bits are zero
    assign m_tdata = {7'd0, out_fill_count, out_read_value, out_status};

endmodule

`default_nettype wire

// ===== tb/pida_result_checker.sv =====
`timescale 1ns / 1ps

module pida_result_checker
    import pida_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    // request: operation, position, value, zero above
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    // result: status, read_value, fill_count, zero above
    input  wire logic [M_TDATA_W-1:0] m_tdata,
    output int                        fail_count,
    output int                        pending_results
);

    localparam int POS_LSB   = OP_W;
    localparam int VALUE_LSB = OP_W + POS_W;
    localparam int RD_LSB    = STATUS_W;
    localparam int FILL_LSB  = STATUS_W + VALUE_W;
    localparam int USED_W    = FILL_LSB + FILL_W;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  read_value;
        logic [FILL_W-1:0]   fill_count;
    } array_result_t;

    logic [VALUE_W-1:0] shadow_words [DEPTH];
    int                 shadow_count;
    array_result_t      expected_results [$];
    int                 mismatches;

    initial begin
        shadow_count    = 0;
        mismatches      = 0;
    end

    // applies one request to the shadow array, returns the result it should give
    function automatic array_result_t apply_request(input logic [OP_W-1:0] op,
                                                    input logic [POS_W-1:0] pos,
                                                    input logic [VALUE_W-1:0] word);
        array_result_t res;
        int            slot;
        res.status     = ST_OK;
        res.read_value = '0;
        case (op)
            OP_INSERT: begin
                if (shadow_count >= DEPTH) begin
                    res.status = ST_FULL;
                end else if (int'(pos) > shadow_count) begin
                    res.status = ST_BADPOS;
                end else begin
                    for (slot = shadow_count; slot > int'(pos); slot--)
                        shadow_words[slot] = shadow_words[slot-1];
                    shadow_words[pos] = word;
                    shadow_count++;
                end
            end
            OP_DELETE: begin
                if (shadow_count == 0) begin
                    res.status = ST_EMPTY;
                end else if (int'(pos) >= shadow_count) begin
                    res.status = ST_BADPOS;
                end else begin
                    for (slot = int'(pos); slot + 1 < shadow_count; slot++)
                        shadow_words[slot] = shadow_words[slot+1];
                    shadow_count--;
                end
            end
            OP_READ: begin
                if (shadow_count == 0)
                    res.status = ST_EMPTY;
                else if (int'(pos) >= shadow_count)
                    res.status = ST_BADPOS;
                else
                    res.read_value = shadow_words[pos];
            end
            default: res.status = ST_BADPOS;
        endcase
        res.fill_count = shadow_count[FILL_W-1:0];
        return res;
    endfunction

    always @(posedge aclk) begin : watch
        array_result_t got;
        array_result_t want;
        if (!aresetn) begin
            shadow_count = 0;
            expected_results.delete();
        end else begin
            // result first: the block registers its output, so an accepted
            // result always belongs to an earlier request
            if (m_tvalid && m_tready) begin
                got.status     = m_tdata[STATUS_W-1:0];
                got.read_value = m_tdata[RD_LSB +: VALUE_W];
                got.fill_count = m_tdata[FILL_LSB +: FILL_W];
                if (expected_results.size() == 0) begin
                    $error("result word with no request outstanding: %h", m_tdata);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                        mismatches++;
                    end
                    if (got.read_value !== want.read_value) begin
                        $error("read_value: expected %0d, actual %0d",
                               $signed(want.read_value), $signed(got.read_value));
                        mismatches++;
                    end
                    if (got.fill_count !== want.fill_count) begin
                        $error("fill_count: expected %0d, actual %0d",
                               want.fill_count, got.fill_count);
                        mismatches++;
                    end
                    if (m_tdata[M_TDATA_W-1:USED_W] !== '0) begin
                        $error("pad bits: expected 0, actual %h", m_tdata[M_TDATA_W-1:USED_W]);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(apply_request(s_tdata[OP_W-1:0],
                                                         s_tdata[POS_LSB +: POS_W],
                                                         s_tdata[VALUE_LSB +: VALUE_W]));
        end
        pending_results <= expected_results.size();
        fail_count      <= mismatches;
    end

endmodule

// ===== tb/positional_insert_delete_array_tb.sv =====
`timescale 1ns / 1ps

module positional_insert_delete_array_tb;

    import pida_pkg::*;

    // code the block does not use, must come back as an invalid position
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS    = 1100;
    localparam int PHASE_LEN       = 100;
    localparam int HOLD_OFF_AT     = 300;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int POS_MAX         = (1 << POS_W) - 1;

    // mixes of operations for the random part
    typedef enum {PHASE_GROW, PHASE_MIXED, PHASE_SHRINK} phase_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // request: [1:0] operation, [8:2] position, [40:9] value, zero above
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // result: [1:0] status, [33:2] read_value, [40:34] fill_count, zero above
    logic [M_TDATA_W-1:0] m_tdata;

    int fail_count;
    int pending_results;

    // fill count as the stimulus sees it, used to aim positions
    int live_count      = 0;
    bit sender_quiet    = 1'b0;
    bit hold_off_request = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    positional_insert_delete_array DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // watches both channels, predicts each result and compares
    pida_result_checker result_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    // idle length before a word: mostly none or short, now and then long
    function automatic int idle_length(input bit quiet);
        int roll;
        if (quiet)
            return 0;
        roll = $urandom_range(99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // value field: extremes and sign patterns now and then, else anything
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(15))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // drives one request word and waits until the block takes it
    task automatic send_request(input logic [OP_W-1:0] op, input int unsigned pos,
                                input logic [VALUE_W-1:0] word);
        logic [S_TDATA_W-1:0] packed_word;
        int                   gap;
        gap         = idle_length(sender_quiet);
        packed_word = '0;
        packed_word[OP_W-1:0]              = op;
        packed_word[OP_W +: POS_W]         = pos[POS_W-1:0];
        packed_word[OP_W + POS_W +: VALUE_W] = word;
        repeat (gap) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= packed_word;
        do @(posedge aclk); while (!s_tready);
        // keep the stimulus view of the count in step with accepted words
        case (op)
            OP_INSERT: if (live_count < DEPTH && pos <= live_count) live_count++;
            OP_DELETE: if (live_count > 0 && pos < live_count) live_count--;
            default: ;
        endcase
    endtask

    // one random word: mostly well-formed for the current count, some noise
    task automatic send_random(input phase_t phase);
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] word;
        int unsigned        pos;
        int                 roll;
        word = pick_value();
        if ($urandom_range(99) < 8) begin
            // noise: any code, any position including the top bit of the field
            op  = OP_W'($urandom_range(3));
            pos = $urandom_range(POS_MAX);
        end else begin
            roll = $urandom_range(99);
            case (phase)
                PHASE_GROW:   op = (roll < 75) ? OP_INSERT : (roll < 87) ? OP_DELETE : OP_READ;
                PHASE_SHRINK: op = (roll < 65) ? OP_DELETE : (roll < 80) ? OP_INSERT : OP_READ;
                default:      op = (roll < 35) ? OP_INSERT : (roll < 65) ? OP_DELETE : OP_READ;
            endcase
            if (op == OP_INSERT)
                pos = $urandom_range(live_count);
            else
                pos = (live_count == 0) ? 0 : $urandom_range(live_count - 1);
            // lean on both ends of the array
            roll = $urandom_range(9);
            if (roll == 0)
                pos = 0;
            else if (roll == 1)
                pos = (op == OP_INSERT) ? live_count : ((live_count == 0) ? 0 : live_count - 1);
        end
        send_request(op, pos, word);
    endtask

    // result side: random stalls, quiet stretches and one long hold-off
    initial begin : result_sink
        int stall_left;
        int stretch_left;
        bit quiet;
        stall_left   = 0;
        stretch_left = 0;
        quiet        = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_request) begin
                // receiver shuts off long enough for the block to back up
                hold_off_request = 1'b0;
                stall_left = HOLD_OFF_CYCLES;
            end
            if (stretch_left == 0) begin
                quiet        = ($urandom_range(3) == 0);
                stretch_left = $urandom_range(200, 50);
            end
            stretch_left--;
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if (!quiet && $urandom_range(99) < 25)
                    stall_left = ($urandom_range(99) < 85) ? $urandom_range(3, 1)
                                                           : $urandom_range(60, 10);
            end
        end
    end

    // stimulus and verdict
    initial begin : stimulus
        int     item;
        phase_t phase;
        phase = PHASE_GROW;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty array: read and delete report empty, even past the end
        send_request(OP_READ,   0,       32'h1234_5678);
        send_request(OP_DELETE, 0,       32'h0);
        send_request(OP_DELETE, POS_MAX, 32'h0);
        // unused code and insert past the end of an empty array
        send_request(OP_UNUSED, 0,       32'h0);
        send_request(OP_INSERT, 1,       32'h0bad_0bad);
        // front, front again, append, middle, then an insert past the end
        send_request(OP_INSERT, 0,       32'h7fff_ffff);
        send_request(OP_INSERT, 0,       32'h8000_0000);
        send_request(OP_INSERT, 2,       32'h0000_0000);
        send_request(OP_INSERT, 1,       32'hffff_ffff);
        send_request(OP_INSERT, POS_MAX, 32'h5555_5555);
        // walk the four entries, then read past the end
        send_request(OP_READ,   0,       32'h0);
        send_request(OP_READ,   1,       32'h0);
        send_request(OP_READ,   2,       32'h0);
        send_request(OP_READ,   3,       32'h0);
        send_request(OP_READ,   4,       32'h0);
        send_request(OP_READ,   POS_MAX, 32'h0);
        // delete past the end, then middle, last and first, then a read and an unused code
        send_request(OP_DELETE, 4,       32'h0);
        send_request(OP_DELETE, 1,       32'h0);
        send_request(OP_DELETE, 2,       32'h0);
        send_request(OP_DELETE, 0,       32'h0);
        send_request(OP_READ,   0,       32'h0);
        send_request(OP_UNUSED, POS_MAX, 32'hffff_ffff);

        // random part: pairs of growing phases push toward full, pairs of shrinking toward empty
        for (item = 0; item < RANDOM_ITEMS; item++) begin
            if (item % PHASE_LEN == 0) begin
                case ((item / PHASE_LEN) % 5)
                    0, 1:    phase = PHASE_GROW;
                    3, 4:    phase = PHASE_SHRINK;
                    default: phase = PHASE_MIXED;
                endcase
                sender_quiet = ($urandom_range(3) == 0);
            end
            if (item == HOLD_OFF_AT)
                hold_off_request = 1'b1;
            send_random(phase);
        end
        s_tvalid <= 1'b0;

        // drain, then leave room for any stray result word
        @(posedge aclk);
        while (pending_results != 0)
            @(posedge aclk);
        repeat (2 * DEPTH + 20) @(posedge aclk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // run limit, far beyond the slowest correct run
    initial begin : watchdog
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/pida_pkg.sv
design/pida_ctrl.sv
design/pida_dp.sv
design/positional_insert_delete_array.sv
tb/pida_result_checker.sv
tb/positional_insert_delete_array_tb.sv
